// ===== hw/rtl/psa_pkg.sv =====
// Shared types, constants and exp tables for the placement swap annealer.
// No dependencies.
`default_nettype none
package psa_pkg;
    localparam int GateCount = 64;
    localparam int NetDepth  = 128;
    localparam int GW = $clog2(GateCount);
    localparam int NW = $clog2(NetDepth);

    localparam logic [1:0] KIND_NET  = 2'd0;
    localparam logic [1:0] KIND_POS  = 2'd1;
    localparam logic [1:0] KIND_SWAP = 2'd2;

    localparam logic [0:0] REG_GREEDY = 1'b0;
    localparam logic [0:0] REG_NETS   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SUM1, ST_SWAPA, ST_SWAPB, ST_SUM2, ST_DIV, ST_EXP1, ST_EXP2,
        ST_DECIDE, ST_UNDOA, ST_UNDOB, ST_OUT
    } psa_state_t;

    typedef struct packed {
        logic start_sum;
        logic sum_second;
        logic swap_rd;
        logic swap_wr;
        logic div_start;
        logic exp1;
        logic exp2;
        logic decide;
    } psa_cmd_t;

    typedef struct packed {
        logic sum_done;
        logic div_done;
        logic keep;
        logic worse;
    } psa_sts_t;

    function automatic logic [16:0] int_tab(input logic [3:0] i);
        case (i)
            4'd0: int_tab = 17'd65536;  4'd1: int_tab = 17'd24109;
            4'd2: int_tab = 17'd8869;   4'd3: int_tab = 17'd3263;
            4'd4: int_tab = 17'd1200;   4'd5: int_tab = 17'd442;
            4'd6: int_tab = 17'd162;    4'd7: int_tab = 17'd60;
            4'd8: int_tab = 17'd22;     4'd9: int_tab = 17'd8;
            4'd10: int_tab = 17'd3;     4'd11: int_tab = 17'd1;
            default: int_tab = 17'd0;
        endcase
    endfunction

    function automatic logic [16:0] hi_tab(input logic [3:0] h);
        case (h)
            4'd0: hi_tab = 17'd65536;  4'd1: hi_tab = 17'd61565;
            4'd2: hi_tab = 17'd57835;  4'd3: hi_tab = 17'd54331;
            4'd4: hi_tab = 17'd51039;  4'd5: hi_tab = 17'd47947;
            4'd6: hi_tab = 17'd45042;  4'd7: hi_tab = 17'd42313;
            4'd8: hi_tab = 17'd39750;  4'd9: hi_tab = 17'd37341;
            4'd10: hi_tab = 17'd35079; 4'd11: hi_tab = 17'd32953;
            4'd12: hi_tab = 17'd30957; 4'd13: hi_tab = 17'd29081;
            4'd14: hi_tab = 17'd27319; default: hi_tab = 17'd25664;
        endcase
    endfunction

    function automatic logic [16:0] lo_tab(input logic [3:0] l);
        case (l)
            4'd0: lo_tab = 17'd65536;  4'd1: lo_tab = 17'd65280;
            4'd2: lo_tab = 17'd65026;  4'd3: lo_tab = 17'd64772;
            4'd4: lo_tab = 17'd64520;  4'd5: lo_tab = 17'd64268;
            4'd6: lo_tab = 17'd64018;  4'd7: lo_tab = 17'd63768;
            4'd8: lo_tab = 17'd63520;  4'd9: lo_tab = 17'd63272;
            4'd10: lo_tab = 17'd63025; 4'd11: lo_tab = 17'd62780;
            4'd12: lo_tab = 17'd62535; 4'd13: lo_tab = 17'd62291;
            4'd14: lo_tab = 17'd62048; default: lo_tab = 17'd61806;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/placement_swap_annealer_top.sv =====
// Placement swap annealer: one linear-placement annealing step per proposal.
// Input channel in_valid/in_stall carries load-net, load-position and
// proposal words; output channel out_valid/out_stall carries one result word
// per proposal. Loads give no result.
// A proposal walks the first nets_in_use nets twice, each net as net read,
// two position reads and accumulate, then runs a restoring divider with a
// 23-bit quotient and two table multiplies when the swap worsens the length.
// One proposal is in flight at once; in_stall stays high from acceptance
// until its result is taken.
// Reset clears the controller and the config registers; the net store and
// position table hold garbage until loaded. A stalled result holds its value.
// Config: cfg_we/cfg_index/cfg_data; write only while idle (not enforced).
`default_nettype none
module placement_swap_annealer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [6:0]  slot,
    input  wire logic [5:0]  source_gate,
    input  wire logic [5:0]  sink_gate,
    input  wire logic [5:0]  place_value,
    input  wire logic [5:0]  swap_first,
    input  wire logic [5:0]  swap_second,
    input  wire logic [7:0]  temperature,
    input  wire logic [15:0] dice,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             accepted,
    output logic [12:0]      length_before,
    output logic [12:0]      length_now
);
    import psa_pkg::*;

    logic       greedy_reg;
    logic [7:0] nets_reg;
    logic       busy;
    logic       acc_in;
    psa_cmd_t   cmd;
    psa_sts_t   sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            greedy_reg <= 1'b0;
            nets_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_GREEDY)
                greedy_reg <= cfg_data[0];
            else
                nets_reg <= cfg_data;
        end
    end

    assign in_stall = busy;
    assign acc_in = in_valid && !busy;

    psa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .go(acc_in && kind == KIND_SWAP),
        .out_taken(!out_stall),
        .sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_valid)
    );

    psa_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .load_net(acc_in && kind == KIND_NET),
        .load_pos(acc_in && kind == KIND_POS),
        .take_prop(acc_in && kind == KIND_SWAP),
        .slot(slot), .source_gate(source_gate), .sink_gate(sink_gate),
        .place_value(place_value), .swap_first(swap_first),
        .swap_second(swap_second), .temperature(temperature), .dice(dice),
        .greedy_mode(greedy_reg), .nets_in_use(nets_reg),
        .cmd(cmd), .sts(sts), .accepted(accepted),
        .length_before(length_before), .length_now(length_now)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(length_now))
        else $error("stalled result changed");
    a_len_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> length_now == length_before)
        else $error("rejected swap changed length");
endmodule
`default_nettype wire

// ===== hw/rtl/psa_ctrl.sv =====
// Controller state machine for the placement swap annealer.
// Depends on psa_pkg.
`default_nettype none
module psa_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           go,
    input  wire logic           out_taken,
    input  wire psa_pkg::psa_sts_t sts,
    output psa_pkg::psa_cmd_t   cmd,
    output logic                busy,
    output logic                out_valid
);
    import psa_pkg::*;

    psa_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (go)
                begin
                    cmd.start_sum = 1'b1;
                    state_next = ST_SUM1;
                end
            end
            ST_SUM1:
                if (sts.sum_done)
                begin
                    cmd.swap_rd = 1'b1;
                    state_next = ST_SWAPA;
                end
            ST_SWAPA:
                state_next = ST_SWAPB;
            ST_SWAPB:
            begin
                cmd.swap_wr = 1'b1;
                cmd.start_sum = 1'b1;
                cmd.sum_second = 1'b1;
                state_next = ST_SUM2;
            end
            ST_SUM2:
                if (sts.sum_done)
                begin
                    if (sts.worse)
                    begin
                        cmd.div_start = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                        state_next = ST_DECIDE;
                end
            ST_DIV:
                if (sts.div_done)
                    state_next = ST_EXP1;
            ST_EXP1:
            begin
                cmd.exp1 = 1'b1;
                state_next = ST_EXP2;
            end
            ST_EXP2:
            begin
                cmd.exp2 = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (sts.keep)
                    state_next = ST_OUT;
                else
                begin
                    cmd.swap_rd = 1'b1;
                    state_next = ST_UNDOA;
                end
            end
            ST_UNDOA:
                state_next = ST_UNDOB;
            ST_UNDOB:
            begin
                cmd.swap_wr = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_taken)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/psa_datapath.sv =====
// Datapath: net store, position table, length accumulator, divider, exp.
// Depends on psa_pkg.
`default_nettype none
module psa_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load_net,
    input  wire logic              load_pos,
    input  wire logic              take_prop,
    input  wire logic [6:0]        slot,
    input  wire logic [5:0]        source_gate,
    input  wire logic [5:0]        sink_gate,
    input  wire logic [5:0]        place_value,
    input  wire logic [5:0]        swap_first,
    input  wire logic [5:0]        swap_second,
    input  wire logic [7:0]        temperature,
    input  wire logic [15:0]       dice,
    input  wire logic              greedy_mode,
    input  wire logic [7:0]        nets_in_use,
    input  wire psa_pkg::psa_cmd_t cmd,
    output psa_pkg::psa_sts_t      sts,
    output logic                   accepted,
    output logic [12:0]            length_before,
    output logic [12:0]            length_now
);
    import psa_pkg::*;

    logic [11:0] net_mem [NetDepth];
    logic [5:0]  pos_mem [GateCount];

    // net walk: phase 0 read net, phase 1 read source pos, phase 2 read sink pos
    logic [NW:0]   idx_reg;
    logic [1:0]    ph_reg;
    logic          sum_run_reg;
    logic [NW:0]   nlim;
    logic [11:0]   net_q_reg;
    logic [5:0]    pos_q_reg;
    logic [5:0]    a_reg;
    logic [13:0]   acc_reg;
    logic [13:0]   before_reg;
    logic [5:0]    ga_reg, gb_reg;
    logic [7:0]    temp_reg;
    logic [15:0]   dice_reg;
    logic          keep_reg;
    logic [5:0]    swa_reg, swb_reg;
    logic [5:0]    rd_addr;
    logic          rd_en;
    logic [5:0]    cur_pos;

    assign nlim = (nets_in_use > 8'(NetDepth)) ? (NW+1)'(NetDepth) : nets_in_use[NW:0];

    always_ff @(posedge clk)
    begin
        if (load_net)
            net_mem[slot[NW-1:0]] <= {source_gate, sink_gate};
        net_q_reg <= net_mem[idx_reg[NW-1:0]];
    end

    always_comb
    begin
        rd_en = 1'b0;
        rd_addr = net_q_reg[11:6];
        if (sum_run_reg && ph_reg == 2'd1)
        begin
            rd_en = 1'b1;
            rd_addr = net_q_reg[11:6];
        end
        else if (sum_run_reg && ph_reg == 2'd2)
        begin
            rd_en = 1'b1;
            rd_addr = net_q_reg[5:0];
        end
        else if (cmd.swap_rd)
        begin
            rd_en = 1'b1;
            rd_addr = ga_reg;
        end
    end

    logic swap_b_rd;
    logic swap_ok;
    assign swap_ok = (ga_reg < 6'(GateCount - 1) + 6'd1 || GateCount == 64) &&
                     (gb_reg < 6'(GateCount - 1) + 6'd1 || GateCount == 64);

    always_ff @(posedge clk)
    begin
        if (load_pos && slot < 7'(GateCount))
            pos_mem[slot[GW-1:0]] <= place_value;
        else if (cmd.swap_wr && swap_ok)
        begin
            pos_mem[ga_reg] <= swb_reg;
            pos_mem[gb_reg] <= swa_reg;
        end
        pos_q_reg <= pos_mem[swap_b_rd ? gb_reg : rd_addr];
        if (rd_en)
            swa_reg <= pos_mem[rd_addr];
        if (swap_b_rd)
            swb_reg <= pos_mem[gb_reg];
    end

    assign cur_pos = pos_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            swap_b_rd <= 1'b0;
        else
            swap_b_rd <= cmd.swap_rd;
    end

    logic [5:0] diff;
    assign diff = (a_reg > cur_pos) ? a_reg - cur_pos : cur_pos - a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_run_reg <= 1'b0;
            ph_reg <= '0;
            idx_reg <= '0;
        end
        else if (cmd.start_sum)
        begin
            sum_run_reg <= (nlim != '0);
            ph_reg <= '0;
            idx_reg <= '0;
        end
        else if (sum_run_reg)
        begin
            if (ph_reg == 2'd3)
            begin
                ph_reg <= '0;
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg + 1'b1 == nlim)
                    sum_run_reg <= 1'b0;
            end
            else
                ph_reg <= ph_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_sum)
            acc_reg <= '0;
        else if (sum_run_reg && ph_reg == 2'd2)
            a_reg <= cur_pos;
        else if (sum_run_reg && ph_reg == 2'd3)
            acc_reg <= acc_reg + 14'(diff);
        if (cmd.start_sum && !cmd.sum_second)
            ; // nothing
        if (cmd.swap_rd && !cmd.decide)
            before_reg <= acc_reg;
        if (take_prop)
        begin
            ga_reg <= swap_first;
            gb_reg <= swap_second;
            temp_reg <= temperature;
            dice_reg <= dice;
        end
    end

    // every 6-bit gate number has a position entry (table is full width here)
    assign sts.sum_done = !sum_run_reg && !cmd.start_sum;
    assign sts.worse = acc_reg > before_reg;

    // restoring divider: delta*512 / temp, 23 bit quotient
    logic [22:0] q_reg;
    logic [8:0]  rem_reg;
    logic [22:0] dvd_reg;
    logic [4:0]  dcnt_reg;
    logic        drun_reg;
    logic [8:0]  rtry;
    assign rtry = {rem_reg[7:0], dvd_reg[22]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drun_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            drun_reg <= (temp_reg != 8'd0) && !greedy_mode;
            dcnt_reg <= '0;
        end
        else if (drun_reg)
        begin
            dcnt_reg <= dcnt_reg + 1'b1;
            if (dcnt_reg == 5'd22)
                drun_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvd_reg <= {acc_reg - before_reg, 9'd0};
            rem_reg <= '0;
            q_reg <= '0;
        end
        else if (drun_reg)
        begin
            dvd_reg <= {dvd_reg[21:0], 1'b0};
            if (rtry >= {1'b0, temp_reg})
            begin
                rem_reg <= rtry - {1'b0, temp_reg};
                q_reg <= {q_reg[21:0], 1'b1};
            end
            else
            begin
                rem_reg <= rtry;
                q_reg <= {q_reg[21:0], 1'b0};
            end
        end
    end
    assign sts.div_done = !drun_reg && !cmd.div_start;

    logic [15:0] r;
    logic [16:0] p_reg;
    logic [33:0] prod;
    logic        zero_p;
    assign r = (q_reg > 23'd65535) ? 16'hFFFF : q_reg[15:0];
    assign zero_p = (r[15:8] >= 8'd12) || greedy_mode || temp_reg == 8'd0;
    assign prod = cmd.exp1 ? int_tab(r[11:8]) * hi_tab(r[7:4])
                           : p_reg * lo_tab(r[3:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.exp1 || cmd.exp2)
            p_reg <= zero_p ? 17'd0 : 17'((prod + 34'd32768) >> 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            keep_reg <= 1'b0;
        else if (cmd.decide)
            keep_reg <= sts.keep;
    end
    // greedy mode and zero temperature reject a worsening swap even at dice 0
    assign sts.keep = !sts.worse ||
                      (!greedy_mode && temp_reg != 8'd0 && {1'b0, dice_reg} <= p_reg);

    assign accepted = keep_reg;
    assign length_before = (before_reg > 14'd8191) ? 13'h1FFF : before_reg[12:0];
    assign length_now = keep_reg ? ((acc_reg > 14'd8191) ? 13'h1FFF : acc_reg[12:0])
                                 : length_before;
endmodule
`default_nettype wire
